@@ hw/rtl/dier_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dier_pkg
// Shared types and constants of the digital input event reporter.
// ----------------------------------------------------------------------------
package dier_pkg;

  localparam int unsigned NUM_CHANNELS = 8;
  // channels that have configuration fields behind them
  localparam int unsigned CFG_CHANNELS = 8;

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PINS_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned TICK_W   = 8;

  localparam int unsigned IN_BITS   = OP_W + PINS_W + TIME_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = ID_W + 1 + TIME_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [TICK_W-1:0] PRESCALE_RESET = TICK_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } dier_op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 3'd0,
    MODE_PERIODIC = 3'd1,
    MODE_RISE     = 3'd2,
    MODE_FALL     = 3'd3,
    MODE_ANY      = 3'd4
  } dier_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT  = 3'd0,
    REG_TRIGGER_MODES  = 3'd1,
    REG_PERIODS_LOW    = 3'd2,
    REG_PERIODS_HIGH   = 3'd3,
    REG_CHANNEL_IDS    = 3'd4,
    REG_PRESCALE_LIMIT = 3'd5
  } dier_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ARM    = 4'b0010,
    ST_SAMPLE = 4'b0100,
    ST_FLUSH  = 4'b1000
  } dier_state_e;

  // one report waiting for its last flag to be known
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            level;
  } dier_pend_t;

endpackage

@@ hw/rtl/digital_input_event_reporter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_input_event_reporter_core
// Samples active-low pins on a prescaled tick and reports periodic and edge
// events per channel, visiting one channel per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata: op, pin_levels, now_seconds
//  m_axis    out        tvalid/tready, tlast   tdata: report_id, report_level,
//                                              report_time; tlast: last_report
//  cfg       in         write enable only      cfg_idx_i, cfg_wdata_i
//
//  a plain tick, a stop, or a tick below the prescale limit is handled in
//  the idle state. a start walks the channels in use in the arm state; a
//  sampling tick walks them in the sample state, then the flush state, and
//  can stall on the output. the walk uses the shared time adder / comparator.
//  s_axis_tready_o is high only while the sequencer is idle.
//  a report is held in a pending register until the next one (or the end of
//  the walk) decides its tlast; the walk stalls only when both it and the
//  output register are full.
//  reset is asynchronous, active low, and clears all but the payload registers.
//
module digital_input_event_reporter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // op [1:0], pin_levels [9:2], now_seconds [41:10], zero fill above
  input  logic [dier_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // report_id [7:0], report_level [8], report_time [40:9], zero fill above
  output logic [dier_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  input  logic                                  cfg_we_i,
  input  logic [dier_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dier_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int unsigned NCH   = dier_pkg::NUM_CHANNELS;
  localparam int unsigned CH_W  = dier_pkg::CH_W;
  localparam int unsigned CNT_W = dier_pkg::CNT_W;
  localparam int unsigned TW    = dier_pkg::TIME_W;

  // configuration registers
  logic [3:0]                      channel_count_q;
  logic [23:0]                     trigger_modes_q;
  logic [63:0]                     periods_low_q;
  logic [63:0]                     periods_high_q;
  logic [63:0]                     channel_ids_q;
  logic [dier_pkg::TICK_W-1:0]     prescale_limit_q;

  // block state
  dier_pkg::dier_state_e           state_q, state_d;
  logic                            enabled_q, enabled_d;
  logic [dier_pkg::TICK_W-1:0]     tick_count_q, tick_count_d;
  logic [NCH-1:0]                  level_q, level_d;
  logic [TW-1:0]                   next_due_q [NCH];
  logic [TW-1:0]                   next_due_d [NCH];
  logic [CNT_W-1:0]                ch_q, ch_d;

  // latched item payload
  logic [TW-1:0]                   now_q, now_d;
  logic [dier_pkg::PINS_W-1:0]     pins_q, pins_d;

  // pending report and output register
  dier_pkg::dier_pend_t            pend_q, pend_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_last_q, out_last_d;
  logic [dier_pkg::ID_W-1:0]       out_id_q, out_id_d;
  logic                            out_level_q, out_level_d;
  logic [TW-1:0]                   out_time_q, out_time_d;

  // per-channel views of the configuration
  logic [dier_pkg::MODE_W-1:0]     mode_arr   [NCH];
  logic [dier_pkg::PERIOD_W-1:0]   period_arr [NCH];
  logic [dier_pkg::ID_W-1:0]       id_arr     [NCH];
  logic [NCH-1:0]                  pin_lvl;

  for (genvar i = 0; i < NCH; i++) begin : g_chan
    if (i < dier_pkg::CFG_CHANNELS) begin : g_cfg
      assign mode_arr[i] = trigger_modes_q[3*i +: 3];
      assign id_arr[i]   = channel_ids_q[8*i +: 8];
      assign pin_lvl[i]  = ~pins_q[i];
      if (i < 4) begin : g_lo
        assign period_arr[i] = periods_low_q[16*i +: 16];
      end else begin : g_hi
        assign period_arr[i] = periods_high_q[16*(i-4) +: 16];
      end
    end else begin : g_none
      // no configuration behind these: mode none, id 0, pin reads high
      assign mode_arr[i]   = dier_pkg::MODE_NONE;
      assign id_arr[i]     = '0;
      assign period_arr[i] = '0;
      assign pin_lvl[i]    = 1'b0;
    end
  end

  // channels in use, saturated
  logic [4:0]       cc_ext;
  logic [CNT_W-1:0] n_active;
  assign cc_ext   = {1'b0, channel_count_q};
  assign n_active = (cc_ext > 5'(NCH)) ? CNT_W'(NCH) : CNT_W'(cc_ext);

  // channel under the sequencer
  logic [CH_W-1:0]                 ch_idx;
  logic                            ch_done;
  logic [dier_pkg::MODE_W-1:0]     cur_mode;
  logic                            cur_lvl;
  logic                            prev_lvl;
  assign ch_idx   = ch_q[CH_W-1:0];
  assign ch_done  = (ch_q >= n_active);
  assign cur_mode = mode_arr[ch_idx];
  assign cur_lvl  = pin_lvl[ch_idx];
  assign prev_lvl = level_q[ch_idx];

  // shared time unit: re-arm sum and due compare
  logic [TW-1:0] due_sum;
  logic          due_hit;
  assign due_sum = now_q + TW'(period_arr[ch_idx]);
  assign due_hit = (now_q >= next_due_q[ch_idx]);

  logic fire;
  always_comb begin
    unique case (cur_mode)
      dier_pkg::MODE_PERIODIC: fire = due_hit;
      dier_pkg::MODE_RISE:     fire = ~prev_lvl & cur_lvl;
      dier_pkg::MODE_FALL:     fire = prev_lvl & ~cur_lvl;
      dier_pkg::MODE_ANY:      fire = prev_lvl ^ cur_lvl;
      default:                 fire = 1'b0;
    endcase
  end

  // input item fields
  logic [dier_pkg::OP_W-1:0]   in_op;
  logic [dier_pkg::PINS_W-1:0] in_pins;
  logic [TW-1:0]               in_now;
  assign in_op   = s_axis_tdata_i[1:0];
  assign in_pins = s_axis_tdata_i[9:2];
  assign in_now  = s_axis_tdata_i[41:10];

  logic in_accept;
  logic out_free;
  assign s_axis_tready_o = (state_q == dier_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    enabled_d    = enabled_q;
    tick_count_d = tick_count_q;
    level_d      = level_q;
    next_due_d   = next_due_q;
    ch_d         = ch_q;
    now_d        = now_q;
    pins_d       = pins_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_last_d   = out_last_q;
    out_id_d     = out_id_q;
    out_level_d  = out_level_q;
    out_time_d   = out_time_q;

    unique case (state_q)
      dier_pkg::ST_IDLE: begin
        if (in_accept) begin
          now_d  = in_now;
          pins_d = in_pins;
          ch_d   = '0;
          unique case (in_op)
            dier_pkg::OP_START: begin
              enabled_d = 1'b1;
              state_d   = dier_pkg::ST_ARM;
            end
            dier_pkg::OP_STOP: begin
              enabled_d = 1'b0;
            end
            dier_pkg::OP_TICK: begin
              if (enabled_q) begin
                if (tick_count_q >= prescale_limit_q) begin
                  // counter restarts at 0 and counts this tick, so it is loaded with 1
                  tick_count_d = dier_pkg::TICK_W'(1);
                  state_d      = dier_pkg::ST_SAMPLE;
                end else begin
                  tick_count_d = tick_count_q + dier_pkg::TICK_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end

      dier_pkg::ST_ARM: begin
        if (ch_done) begin
          state_d = dier_pkg::ST_IDLE;
        end else begin
          if (cur_mode == dier_pkg::MODE_PERIODIC) begin
            next_due_d[ch_idx] = due_sum;
          end
          ch_d = ch_q + CNT_W'(1);
        end
      end

      dier_pkg::ST_SAMPLE: begin
        if (ch_done) begin
          state_d = dier_pkg::ST_FLUSH;
        end else if (!(fire && pend_q.valid && !out_free)) begin
          level_d[ch_idx] = cur_lvl;
          if (fire) begin
            if (cur_mode == dier_pkg::MODE_PERIODIC) begin
              next_due_d[ch_idx] = due_sum;
            end
            if (pend_q.valid) begin
              // a later report exists, so the held one is not the last
              out_valid_d = 1'b1;
              out_last_d  = 1'b0;
              out_id_d    = pend_q.id;
              out_level_d = pend_q.level;
              out_time_d  = now_q;
            end
            pend_d.valid = 1'b1;
            pend_d.id    = id_arr[ch_idx];
            pend_d.level = cur_lvl;
          end
          ch_d = ch_q + CNT_W'(1);
        end
      end

      dier_pkg::ST_FLUSH: begin
        if (!pend_q.valid) begin
          state_d = dier_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_id_d     = pend_q.id;
          out_level_d  = pend_q.level;
          out_time_d   = now_q;
          pend_d.valid = 1'b0;
          state_d      = dier_pkg::ST_IDLE;
        end
      end

      default: state_d = dier_pkg::ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q  <= '0;
      trigger_modes_q  <= '0;
      periods_low_q    <= '0;
      periods_high_q   <= '0;
      channel_ids_q    <= '0;
      prescale_limit_q <= dier_pkg::PRESCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dier_pkg::REG_CHANNEL_COUNT:  channel_count_q  <= cfg_wdata_i[3:0];
        dier_pkg::REG_TRIGGER_MODES:  trigger_modes_q  <= cfg_wdata_i[23:0];
        dier_pkg::REG_PERIODS_LOW:    periods_low_q    <= cfg_wdata_i;
        dier_pkg::REG_PERIODS_HIGH:   periods_high_q   <= cfg_wdata_i;
        dier_pkg::REG_CHANNEL_IDS:    channel_ids_q    <= cfg_wdata_i;
        dier_pkg::REG_PRESCALE_LIMIT: prescale_limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // control state and timers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dier_pkg::ST_IDLE;
      enabled_q    <= 1'b0;
      tick_count_q <= '0;
      level_q      <= '0;
      ch_q         <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        next_due_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      enabled_q    <= enabled_d;
      tick_count_q <= tick_count_d;
      level_q      <= level_d;
      ch_q         <= ch_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      next_due_q   <= next_due_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    pins_q      <= pins_d;
    out_last_q  <= out_last_d;
    out_id_q    <= out_id_d;
    out_level_q <= out_level_d;
    out_time_q  <= out_time_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {(dier_pkg::OUT_DATA_W - dier_pkg::OUT_BITS)'(0),
                            out_time_q, out_level_q, out_id_q};

endmodule

@@ dv/digital_input_event_reporter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_input_event_reporter_core_tb
// Streams start, stop and tick commands into the reporter under several
// channel setups, predicts every periodic and edge report in the testbench
// and checks the report stream field by field, with random stalls on both
// sides of the block.
// ----------------------------------------------------------------------------
module digital_input_event_reporter_core_tb;
  import dier_pkg::*;

  // op code 3 has no name in the package and must be ignored by the block
  localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
  // mode codes above any-edge behave as no trigger
  localparam logic [MODE_W-1:0]    MODE_UNUSED_5 = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_7 = 3'd7;
  // register indexes past the list are dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7  = 3'd7;

  // margin for a start or a sampling tick to walk all channels
  localparam int unsigned SETTLE_CYCLES = 2 * NUM_CHANNELS + 8;
  localparam int unsigned NUM_PHASES    = 12;

  // op in the lowest bits, as on s_axis tdata
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [PINS_W-1:0] pins;
    logic [OP_W-1:0]   op;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              level;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk_i = ~clk_i;

  digital_input_event_reporter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // shadow of the register file and of the block state
  // --------------------------------------------------------------------------
  logic [3:0]            sh_count      = '0;
  logic [23:0]           sh_modes      = '0;
  logic [63:0]           sh_periods_lo = '0;
  logic [63:0]           sh_periods_hi = '0;
  logic [63:0]           sh_ids        = '0;
  logic [TICK_W-1:0]     sh_limit      = PRESCALE_RESET;

  logic                  sh_enabled    = 1'b0;
  logic [TICK_W-1:0]     sh_ticks      = '0;
  logic [NUM_CHANNELS-1:0] sh_level    = '0;
  logic [TIME_W-1:0]     sh_due [NUM_CHANNELS];

  initial begin
    foreach (sh_due[i]) sh_due[i] = '0;
  end

  cmd_t    cmd_q[$];      // commands waiting for the driver
  report_t report_q[$];   // reports predicted but not yet seen on m_axis

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 79;
  int unsigned mismatch_count = 0;

  // works out the reports of one accepted command and updates the shadow state
  function automatic void predict_reports(cmd_t cmd);
    int unsigned n;
    logic        prev;
    logic        lvl;
    logic        fire;
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] period;
    report_t     batch[$];
    report_t     rpt;
    n = (sh_count > NUM_CHANNELS) ? NUM_CHANNELS : 32'(sh_count);
    case (cmd.op)
      OP_START: begin
        for (int ch = 0; ch < n; ch++) begin
          mode   = sh_modes[MODE_W*ch +: MODE_W];
          period = (ch < 4) ? sh_periods_lo[PERIOD_W*ch +: PERIOD_W]
                            : sh_periods_hi[PERIOD_W*(ch-4) +: PERIOD_W];
          if (mode == MODE_PERIODIC) sh_due[ch] = cmd.now + TIME_W'(period);
        end
        sh_enabled = 1'b1;
      end
      OP_STOP: sh_enabled = 1'b0;
      OP_TICK: begin
        if (sh_enabled) begin
          if (sh_ticks >= sh_limit) begin
            sh_ticks = '0;
            for (int ch = 0; ch < n; ch++) begin
              mode   = sh_modes[MODE_W*ch +: MODE_W];
              period = (ch < 4) ? sh_periods_lo[PERIOD_W*ch +: PERIOD_W]
                                : sh_periods_hi[PERIOD_W*(ch-4) +: PERIOD_W];
              prev   = sh_level[ch];
              lvl    = ~cmd.pins[ch];   // pins are active low
              sh_level[ch] = lvl;
              fire   = 1'b0;
              case (mode)
                MODE_PERIODIC: begin
                  if (cmd.now >= sh_due[ch]) begin
                    fire       = 1'b1;
                    sh_due[ch] = cmd.now + TIME_W'(period);
                  end
                end
                MODE_RISE: fire = !prev && lvl;
                MODE_FALL: fire = prev && !lvl;
                MODE_ANY:  fire = prev != lvl;
                default:   fire = 1'b0;
              endcase
              if (fire) begin
                rpt.id    = sh_ids[ID_W*ch +: ID_W];
                rpt.level = lvl;
                rpt.stamp = cmd.now;
                rpt.last  = 1'b0;
                batch.push_back(rpt);
              end
            end
            // tlast marks the final report caused by this tick
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) report_q.push_back(batch[i]);
          end
          sh_ticks = sh_ticks + TICK_W'(1);
        end
      end
      default: ;  // unused op code, no effect
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // driver: inputs change at the falling edge
  // --------------------------------------------------------------------------
  logic in_taken = 1'b0;   // s_axis transaction completed at the last rising edge
  cmd_t drv_cmd;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // hold the current transaction until the block takes it
      if (!s_tvalid || in_taken) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_cmd  = cmd_q.pop_front();
          s_tdata  <= IN_DATA_W'({drv_cmd.now, drv_cmd.pins, drv_cmd.op});
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: both streams sampled at the rising edge
  // --------------------------------------------------------------------------
  report_t got;
  report_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.id    = m_tdata[ID_W-1:0];
        got.level = m_tdata[ID_W];
        got.stamp = m_tdata[ID_W+1 +: TIME_W];
        got.last  = m_tlast;
        if (report_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: report with none expected: id %h level %b time %h last %b",
                   $time, got.id, got.level, got.stamp, got.last);
        end else begin
          want = report_q.pop_front();
          if (got.id !== want.id) begin
            mismatch_count++;
            $display("%0t: report_id expected %h actual %h", $time, want.id, got.id);
          end
          if (got.level !== want.level) begin
            mismatch_count++;
            $display("%0t: report_level expected %b actual %b", $time, want.level,
                     got.level);
          end
          if (got.stamp !== want.stamp) begin
            mismatch_count++;
            $display("%0t: report_time expected %h actual %h", $time, want.stamp,
                     got.stamp);
          end
          if (got.last !== want.last) begin
            mismatch_count++;
            $display("%0t: last_report expected %b actual %b", $time, want.last,
                     got.last);
          end
        end
      end
      // predict after checking; a command never reports at its own edge
      if (s_tvalid && s_tready) predict_reports(cmd_t'(s_tdata[OP_W+PINS_W+TIME_W-1:0]));
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cmd(logic [OP_W-1:0] op, logic [PINS_W-1:0] pins,
                          logic [TIME_W-1:0] now);
    cmd_t c;
    c.op   = op;
    c.pins = pins;
    c.now  = now;
    cmd_q.push_back(c);
  endtask

  // one register write; the shadow follows at once since the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CHANNEL_COUNT:  sh_count      = val[3:0];
      REG_TRIGGER_MODES:  sh_modes      = val[23:0];
      REG_PERIODS_LOW:    sh_periods_lo = val;
      REG_PERIODS_HIGH:   sh_periods_hi = val;
      REG_CHANNEL_IDS:    sh_ids        = val;
      REG_PRESCALE_LIMIT: sh_limit      = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_setup(logic [3:0] count, logic [23:0] modes, logic [63:0] per_lo,
                             logic [63:0] per_hi, logic [63:0] ids, logic [7:0] limit);
    // upper bits of the narrow registers carry junk that must be dropped
    write_reg(REG_CHANNEL_COUNT, {$urandom, $urandom} & ~64'hF | 64'(count));
    write_reg(REG_TRIGGER_MODES, {$urandom, $urandom} & ~64'hFF_FFFF | 64'(modes));
    write_reg(REG_PERIODS_LOW, per_lo);
    write_reg(REG_PERIODS_HIGH, per_hi);
    write_reg(REG_CHANNEL_IDS, ids);
    write_reg(REG_PRESCALE_LIMIT, {$urandom, $urandom} & ~64'hFF | 64'(limit));
    write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, {$urandom, $urandom});
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every command is taken and every report is out, then let
  // a start or a silent sampling walk finish before touching the registers
  task automatic drain();
    while (cmd_q.size() != 0 || s_tvalid || report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] pick_start_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 1000);
    if (r < 8) return 32'hFFFF_FFF0 + $urandom_range(0, 15);  // close to wrap
    return $urandom;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return PERIOD_W'($urandom_range(0, 6));
    if (r < 8) return '1;
    if (r < 9) return '0;
    return PERIOD_W'($urandom);
  endfunction

  // mostly well-formed runs: a start, then ticks with slowly moving time and
  // pins; now and then a stop, a restart, a time jump or an unused op code
  task automatic queue_run(int unsigned n_ticks);
    logic [TIME_W-1:0] now;
    logic [PINS_W-1:0] pins;
    logic              on;
    int unsigned       r;
    now  = pick_start_time();
    pins = PINS_W'($urandom);
    push_cmd(OP_START, PINS_W'($urandom), now);
    on = 1'b1;
    for (int unsigned k = 0; k < n_ticks; k++) begin
      r = $urandom_range(0, 99);
      if (!on && r < 40) begin
        push_cmd(OP_START, PINS_W'($urandom), now);
        on = 1'b1;
      end else if (r < 3) begin
        push_cmd(OP_STOP, PINS_W'($urandom), now);
        on = 1'b0;
      end else if (r < 5) begin
        push_cmd(OP_START, PINS_W'($urandom), now);   // restart while running
        on = 1'b1;
      end else if (r < 7) begin
        push_cmd(OP_UNUSED, PINS_W'($urandom), $urandom);
      end else if (r < 8) begin
        now = $urandom;
      end
      now  = now + $urandom_range(0, 3);
      // each pin flips about a quarter of the time
      pins = pins ^ PINS_W'($urandom & $urandom);
      push_cmd(OP_TICK, pins, now);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  logic [3:0]  ph_count;
  logic [23:0] ph_modes;
  logic [63:0] ph_per_lo;
  logic [63:0] ph_per_hi;
  logic [7:0]  ph_limit;
  int unsigned ph_ticks;
  int unsigned m;

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: a channel of every mode (two periodic), unused codes, wrap of time
    write_setup(4'd8,
                {MODE_UNUSED_7, MODE_UNUSED_5, MODE_NONE, MODE_PERIODIC,
                 MODE_ANY, MODE_FALL, MODE_RISE, MODE_PERIODIC},
                {16'd9, 16'd9, 16'd9, 16'd0},
                {16'd0, 16'd0, 16'd0, 16'hFFFF},
                64'hFF00_A55A_8001_7F10, 8'd0);
    push_cmd(OP_TICK, 8'h00, 32'd0);            // disabled, ignored
    push_cmd(OP_STOP, 8'h00, 32'd0);            // stop while disabled
    push_cmd(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    push_cmd(OP_START, 8'h00, 32'd100);
    push_cmd(OP_TICK, 8'hFF, 32'd100);          // periodic due right at start
    push_cmd(OP_TICK, 8'h00, 32'd101);          // all rise
    push_cmd(OP_TICK, 8'hFF, 32'd102);          // all fall
    push_cmd(OP_TICK, 8'h0F, 32'd103);
    push_cmd(OP_START, 8'h00, 32'hFFFF_FFF0);   // restart, long period wraps
    push_cmd(OP_TICK, 8'hF0, 32'hFFFF_FFF0);
    push_cmd(OP_TICK, 8'h00, 32'd0);            // time wrapped to zero
    push_cmd(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
    push_cmd(OP_STOP, 8'h00, 32'd5);
    push_cmd(OP_TICK, 8'h00, 32'd6);            // disabled, levels untouched
    push_cmd(OP_START, 8'h00, 32'd7);
    push_cmd(OP_TICK, 8'hAA, 32'd7);
    push_cmd(OP_TICK, 8'h55, 32'd8);
    drain();

    // directed: channel count above eight saturates, all any-edge
    write_setup(4'd15, {NUM_CHANNELS{MODE_ANY}}, '1, '1, 64'h0123_4567_89AB_CDEF, 8'd1);
    push_cmd(OP_START, 8'h00, 32'd0);
    push_cmd(OP_TICK, 8'h5A, 32'd1);
    push_cmd(OP_TICK, 8'hA5, 32'd2);
    push_cmd(OP_TICK, 8'h3C, 32'd3);
    push_cmd(OP_TICK, 8'hC3, 32'd4);
    drain();

    // random phases: idling pattern changes every third of the way
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 79;
      end else if (p < 2 * NUM_PHASES / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      m = $urandom_range(0, 9);
      if (p == 3 || m == 0) ph_count = 4'd0;
      else if (m == 1)      ph_count = 4'($urandom_range(9, 15));
      else                  ph_count = 4'($urandom_range(1, 8));
      if (p == 7) ph_count = 4'd8;

      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        m = $urandom_range(0, 11);
        ph_modes[MODE_W*ch +: MODE_W] = MODE_W'((m > 7) ? m - 7 : m);
      end
      if (p == 9) ph_modes = 24'($urandom);

      for (int ch = 0; ch < 4; ch++) begin
        ph_per_lo[PERIOD_W*ch +: PERIOD_W] = pick_period();
        ph_per_hi[PERIOD_W*ch +: PERIOD_W] = pick_period();
      end

      // the largest, smallest and reset prescale limits get their own phases; the rest stay fast
      ph_ticks = 12;
      if (p == 5) begin
        ph_limit = 8'd255;
        ph_ticks = 300;
      end else if (p == 10) begin
        ph_limit = PRESCALE_RESET;
        ph_ticks = 40;
      end else if (p == 1) begin
        ph_limit = 8'd0;
      end else begin
        ph_limit = 8'($urandom_range(0, 3));
      end

      write_setup(ph_count, ph_modes, ph_per_lo, ph_per_hi,
                  (p == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom}, ph_limit);
      queue_run(ph_ticks);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
